// File: rtl/xcpr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcpr_pkg
// Shared constants and types of the framed packet responder.
// ----------------------------------------------------------------------------
package xcpr_pkg;

  localparam int MAX_PAYLOAD = 59;

  localparam logic [7:0] START_BYTE = 8'hAA;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_READ    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NACK    = 3'd4;

  localparam logic [15:0] TIMEOUT_RST = 16'd50;
  localparam logic [7:0]  WRITE_RST   = 8'd1;
  localparam logic [7:0]  READ_RST    = 8'd2;
  localparam logic [7:0]  ACK_RST     = 8'd3;
  localparam logic [7:0]  NACK_RST    = 8'd4;

  // one reply job handed from the parser to the reply generator
  typedef struct packed {
    logic       nack;  // checksum failure reply
    logic       data;  // reply carries the stored payload
    logic       bank;  // payload buffer bank
    logic [7:0] addr;
    logic [7:0] len;
  } cmd_t;

endpackage

// File: rtl/xcpr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcpr_in_if / xcpr_out_if
// Valid/ready channels: received bytes and ticks in, reply bytes out.
// ----------------------------------------------------------------------------
interface xcpr_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] rx_data;

  modport source (output valid, output action, output rx_data, input ready);
  modport sink (input valid, input action, input rx_data, output ready);
endinterface

interface xcpr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       last_of_run;

  modport source (output valid, output tx_byte, output last_of_run, input ready);
  modport sink (input valid, input tx_byte, input last_of_run, output ready);
endinterface

// File: rtl/xor_checked_packet_responder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xor_checked_packet_responder
// Framed request parser with XOR check and byte-wise reply generator.
//
// rx_in carries one beat per received byte (action 0) or time tick
// (action 1). Packets are 0xAA, opcode, address, length, payload, XOR.
// tx_out carries reply bytes, last_of_run set on the trailing XOR byte.
// Config writes (cfg_we/cfg_index/cfg_data) take effect the next cycle;
// write them only while the block is quiet.
// rx_in accepts one beat per cycle. It holds ready low on a payload or
// checksum beat while the fill bank of the two-bank payload buffer is still
// being replayed, or on a checksum beat while the two-entry job queue is full.
// The first reply byte passes the job queue, the generator state and the output
// register after its checksum beat; header and trailer bytes go out one per
// cycle while tx_out is ready, and each payload byte waits on a registered
// buffer read first.
// When tx_out stalls the pending byte holds and the parser keeps running
// until the buffer or queue backs up.
// Synchronous reset clears parser, queue and output; registers go to their
// defaults (timeout 50, codes 1, 2, 3, 4). No clearing pass is needed.
// ----------------------------------------------------------------------------
module xor_checked_packet_responder #(
  parameter int MAX_PAYLOAD = xcpr_pkg::MAX_PAYLOAD
) (
  input  logic                            clk,
  input  logic                            rst,
  xcpr_in_if.sink                         rx_in,
  xcpr_out_if.source                      tx_out,
  input  logic                            cfg_we,
  input  logic [xcpr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [xcpr_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int AW        = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int RAM_DEPTH = 2 * (2 ** AW);

  logic [15:0] timeout_ticks;
  logic [7:0]  write_code;
  logic [7:0]  read_code;
  logic [7:0]  ack_code;
  logic [7:0]  nack_code;

  logic           pwr_en;
  logic [AW:0]    pwr_addr;
  logic [7:0]     pwr_data;
  logic           prd_en;
  logic [AW:0]    prd_addr;
  logic [7:0]     prd_data;
  logic           push;
  logic           pop;
  logic           full;
  logic           empty;
  xcpr_pkg::cmd_t push_cmd;
  logic           push_ok;
  xcpr_pkg::cmd_t pop_cmd;
  logic           rel;
  logic           rel_bank;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= xcpr_pkg::TIMEOUT_RST;
      write_code    <= xcpr_pkg::WRITE_RST;
      read_code     <= xcpr_pkg::READ_RST;
      ack_code      <= xcpr_pkg::ACK_RST;
      nack_code     <= xcpr_pkg::NACK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        xcpr_pkg::CFG_TIMEOUT: timeout_ticks <= cfg_data;
        xcpr_pkg::CFG_WRITE:   write_code    <= cfg_data[7:0];
        xcpr_pkg::CFG_READ:    read_code     <= cfg_data[7:0];
        xcpr_pkg::CFG_ACK:     ack_code      <= cfg_data[7:0];
        xcpr_pkg::CFG_NACK:    nack_code     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  xcpr_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .AW          (AW)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .rx_in         (rx_in),
    .timeout_ticks (timeout_ticks),
    .write_code    (write_code),
    .read_code     (read_code),
    .pwr_en        (pwr_en),
    .pwr_addr      (pwr_addr),
    .pwr_data      (pwr_data),
    .push          (push),
    .push_cmd      (push_cmd),
    .full          (full),
    .rel           (rel),
    .rel_bank      (rel_bank)
  );

  assign push_ok = push && !full;

  xcpr_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push_ok),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (empty)
  );

  xcpr_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_payload (
    .clk   (clk),
    .we    (pwr_en),
    .waddr (pwr_addr),
    .wdata (pwr_data),
    .re    (prd_en),
    .raddr (prd_addr),
    .rdata (prd_data)
  );

  xcpr_back #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .AW          (AW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .ack_code  (ack_code),
    .nack_code (nack_code),
    .pop       (pop),
    .pop_cmd   (pop_cmd),
    .empty     (empty),
    .prd_en    (prd_en),
    .prd_addr  (prd_addr),
    .prd_data  (prd_data),
    .rel       (rel),
    .rel_bank  (rel_bank),
    .tx_out    (tx_out)
  );

endmodule

// File: rtl/xcpr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcpr_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module xcpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/xcpr_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcpr_cmd_fifo
// Two-entry queue of reply jobs between the parser and the reply generator.
// ----------------------------------------------------------------------------
module xcpr_cmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  xcpr_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output xcpr_pkg::cmd_t pop_cmd,
  output logic           empty
);

  xcpr_pkg::cmd_t q [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;

  assign full    = cnt == 2'd2;
  assign empty   = cnt == 2'd0;
  assign pop_cmd = q[rp];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      q[wp] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push && !full) begin
        wp <= ~wp;
      end
      if (pop && !empty) begin
        rp <= ~rp;
      end
      case ({push && !full, pop && !empty})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("reply job pushed into a full queue");
  assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("reply job popped from an empty queue");
  assert property (@(posedge clk) disable iff (rst)
    (push && !pop && !full) |=> !empty)
    else $error("queue empty after a push");

endmodule

// File: rtl/xcpr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcpr_front
// Packet parser: frames requests, stores payload, checks XOR, queues replies.
// ----------------------------------------------------------------------------
module xcpr_front #(
  parameter int MAX_PAYLOAD = xcpr_pkg::MAX_PAYLOAD,
  parameter int AW          = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
  input  logic            clk,
  input  logic            rst,
  xcpr_in_if.sink         rx_in,
  input  logic [15:0]     timeout_ticks,
  input  logic [7:0]      write_code,
  input  logic [7:0]      read_code,
  // payload buffer write port
  output logic            pwr_en,
  output logic [AW:0]     pwr_addr,
  output logic [7:0]      pwr_data,
  // reply queue
  output logic            push,
  output xcpr_pkg::cmd_t  push_cmd,
  input  logic            full,
  // bank released by the reply generator
  input  logic            rel,
  input  logic            rel_bank
);

  localparam logic [2:0] PH_WAIT = 3'd0;
  localparam logic [2:0] PH_OPC  = 3'd1;
  localparam logic [2:0] PH_ADDR = 3'd2;
  localparam logic [2:0] PH_LEN  = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;
  localparam logic [2:0] PH_CHK  = 3'd5;

  logic [2:0]  phase;
  logic [7:0]  opc;
  logic [7:0]  addr;
  logic [7:0]  len;
  logic [AW-1:0] count;
  logic [7:0]  chk;
  logic [15:0] idle;
  logic        wbank;
  logic [1:0]  busy;
  logic [1:0]  busy_next;

  logic        stall;
  logic        accept;
  logic        is_byte;
  logic [7:0]  b;
  logic [15:0] idle_inc;
  logic [AW:0] count_inc;
  logic        bad;

  assign b       = rx_in.rx_data;
  assign is_byte = !rx_in.action;

  // hold off while the fill bank is still being replayed or the queue is full
  assign stall = ((phase == PH_DATA || phase == PH_CHK) && busy[wbank]) ||
                 (phase == PH_CHK && full);
  assign rx_in.ready = !stall;
  assign accept      = rx_in.valid && !stall;

  assign idle_inc  = (idle == 16'hFFFF) ? idle : idle + 16'd1;
  assign count_inc = {1'b0, count} + {{AW{1'b0}}, 1'b1};
  assign bad       = b != chk;

  assign pwr_en   = accept && is_byte && phase == PH_DATA;
  assign pwr_addr = {wbank, count};
  assign pwr_data = b;

  assign push = accept && is_byte && phase == PH_CHK &&
                (bad || opc == write_code || opc == read_code);

  always_comb begin
    push_cmd.nack = bad;
    push_cmd.data = !bad && opc == write_code;
    push_cmd.bank = wbank;
    push_cmd.addr = bad ? 8'd0 : addr;
    push_cmd.len  = (!bad && opc == write_code) ? len : 8'd0;
  end

  // release and claim never hit the same bank: a claim waits on a busy bank
  always_comb begin
    busy_next = busy;
    if (rel) begin
      busy_next[rel_bank] = 1'b0;
    end
    if (push && push_cmd.data) begin
      busy_next[wbank] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_WAIT;
      opc   <= 8'd0;
      addr  <= 8'd0;
      len   <= 8'd0;
      count <= '0;
      chk   <= 8'd0;
      idle  <= 16'd0;
      wbank <= 1'b0;
      busy  <= 2'b00;
    end else begin
      busy <= busy_next;
      if (push && push_cmd.data) begin
        wbank <= ~wbank;
      end
      if (accept && !is_byte) begin
        if (phase != PH_WAIT) begin
          idle <= idle_inc;
          if (idle_inc > timeout_ticks) begin
            phase <= PH_WAIT;
            count <= '0;
          end
        end
      end else if (accept) begin
        idle <= 16'd0;
        case (phase)
          PH_OPC: begin
            opc   <= b;
            chk   <= chk ^ b;
            phase <= PH_ADDR;
          end
          PH_ADDR: begin
            addr  <= b;
            chk   <= chk ^ b;
            phase <= PH_LEN;
          end
          PH_LEN: begin
            len   <= b;
            chk   <= chk ^ b;
            count <= '0;
            if (b > 8'(MAX_PAYLOAD)) begin
              phase <= PH_WAIT;
            end else if (b != 8'd0) begin
              phase <= PH_DATA;
            end else begin
              phase <= PH_CHK;
            end
          end
          PH_DATA: begin
            chk   <= chk ^ b;
            count <= count_inc[AW-1:0];
            if (9'(count_inc) >= {1'b0, len}) begin
              phase <= PH_CHK;
            end
          end
          PH_CHK: begin
            phase <= PH_WAIT;
          end
          default: begin
            if (b == xcpr_pkg::START_BYTE) begin
              count <= '0;
              chk   <= 8'd0;
              phase <= PH_OPC;
            end else begin
              phase <= PH_WAIT;
            end
          end
        endcase
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) pwr_en |-> !busy[wbank])
    else $error("payload written into a bank still being replied");
  assert property (@(posedge clk) disable iff (rst)
    (push && push_cmd.data) |=> busy[~wbank])
    else $error("write reply bank not marked busy");
  assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("reply queued while queue full");

endmodule

// File: rtl/xcpr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcpr_back
// Reply generator: walks one queued job out byte by byte with XOR trailer.
// ----------------------------------------------------------------------------
module xcpr_back #(
  parameter int MAX_PAYLOAD = xcpr_pkg::MAX_PAYLOAD,
  parameter int AW          = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [7:0]     ack_code,
  input  logic [7:0]     nack_code,
  // reply queue
  output logic           pop,
  input  xcpr_pkg::cmd_t pop_cmd,
  input  logic           empty,
  // payload buffer read port
  output logic           prd_en,
  output logic [AW:0]    prd_addr,
  input  logic [7:0]     prd_data,
  // bank release
  output logic           rel,
  output logic           rel_bank,
  xcpr_out_if.source     tx_out
);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_HDR  = 3'd1;
  localparam logic [2:0] B_RDA  = 3'd2;
  localparam logic [2:0] B_DAT  = 3'd3;
  localparam logic [2:0] B_SUM  = 3'd4;

  logic [2:0]     state;
  xcpr_pkg::cmd_t cmd;
  logic [1:0]     pos;
  logic [AW-1:0]  k;
  logic [7:0]     sum;
  logic           ovalid;
  logic [7:0]     obyte;
  logic           olast;

  logic           free;
  logic           load;
  logic [7:0]     hdr_byte;
  logic [AW:0]    k_inc;

  assign free  = !ovalid || tx_out.ready;
  assign load  = free && (state == B_HDR || state == B_DAT || state == B_SUM);
  assign k_inc = {1'b0, k} + {{AW{1'b0}}, 1'b1};

  assign pop      = state == B_IDLE && !empty;
  assign prd_en   = state == B_RDA;
  assign prd_addr = {cmd.bank, k};
  assign rel      = state == B_SUM && free && cmd.data;
  assign rel_bank = cmd.bank;

  assign tx_out.valid       = ovalid;
  assign tx_out.tx_byte     = obyte;
  assign tx_out.last_of_run = olast;

  always_comb begin
    case (pos)
      2'd0:    hdr_byte = xcpr_pkg::START_BYTE;
      2'd1:    hdr_byte = cmd.nack ? nack_code : ack_code;
      2'd2:    hdr_byte = cmd.addr;
      default: hdr_byte = cmd.len;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd <= pop_cmd;
    end
    if (state == B_HDR && free) begin
      obyte <= hdr_byte;
    end else if (state == B_DAT && free) begin
      obyte <= prd_data;
    end else if (state == B_SUM && free) begin
      obyte <= sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= B_IDLE;
      pos    <= 2'd0;
      k      <= '0;
      sum    <= 8'd0;
      ovalid <= 1'b0;
      olast  <= 1'b0;
    end else begin
      if (load) begin
        ovalid <= 1'b1;
      end else if (tx_out.ready) begin
        ovalid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (!empty) begin
            pos   <= 2'd0;
            sum   <= 8'd0;
            state <= B_HDR;
          end
        end
        B_HDR: begin
          if (free) begin
            olast  <= 1'b0;
            pos    <= pos + 2'd1;
            if (pos != 2'd0) begin
              sum <= sum ^ hdr_byte;
            end
            if (pos == 2'd3) begin
              k <= '0;
              if (cmd.data && cmd.len != 8'd0) begin
                state <= B_RDA;
              end else begin
                state <= B_SUM;
              end
            end
          end
        end
        B_RDA: begin
          state <= B_DAT;
        end
        B_DAT: begin
          if (free) begin
            olast  <= 1'b0;
            sum    <= sum ^ prd_data;
            k      <= k_inc[AW-1:0];
            if (9'(k_inc) == {1'b0, cmd.len}) begin
              state <= B_SUM;
            end else begin
              state <= B_RDA;
            end
          end
        end
        B_SUM: begin
          if (free) begin
            olast  <= 1'b1;
            state  <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    state == B_DAT |-> $past(state) == B_RDA || $past(state) == B_DAT)
    else $error("payload byte taken without a read issued");
  assert property (@(posedge clk) disable iff (rst)
    (state == B_SUM && free) |=> ovalid && olast)
    else $error("checksum byte not marked last");
  assert property (@(posedge clk) disable iff (rst) rel |-> cmd.data)
    else $error("bank released by a reply without payload");

endmodule
